// ===== src/iphc_pkg.sv =====
package iphc_pkg;

  // Default depth of the queue between the header parser and the checksum unit.
  localparam int IPHC_QUEUE_DEPTH = 2;

  // Byte positions of the captured header fields.
  localparam logic [5:0] IPHC_POS_VERSION  = 6'd0;
  localparam logic [5:0] IPHC_POS_PROTOCOL = 6'd9;
  localparam logic [5:0] IPHC_POS_SRC_LO   = 6'd12;
  localparam logic [5:0] IPHC_POS_DST_LO   = 6'd16;
  localparam logic [5:0] IPHC_POS_OPTIONS  = 6'd20;
  localparam logic [5:0] IPHC_POS_MAX      = 6'd63;

  // Fixed header size in bytes.
  localparam logic [6:0] IPHC_MIN_HDR_BYTES = 7'd20;

  // Option codes and option length limits.
  localparam logic [7:0] IPHC_OPT_EOL          = 8'd0;
  localparam logic [7:0] IPHC_OPT_NOP          = 8'd1;
  localparam logic [7:0] IPHC_OPT_LSRR         = 8'd131;
  localparam logic [7:0] IPHC_OPT_SSRR         = 8'd137;
  localparam logic [7:0] IPHC_OPT_MIN_LEN      = 8'd2;
  localparam logic [7:0] IPHC_ROUTE_MIN_LEN    = 8'd7;
  localparam logic [8:0] IPHC_ROUTE_TAIL_BYTES = 9'd4;

  // Option walker phase.
  typedef enum logic [2:0] {
    PH_TYPE = 3'b001,
    PH_LEN  = 3'b010,
    PH_BODY = 3'b100
  } iphc_phase_t;

  // One header byte with its side fields.
  typedef struct packed {
    logic [7:0]  header_byte;
    logic        byte_last;
    logic [15:0] partial_checksum;
    logic [15:0] transport_length;
  } iphc_in_t;

  // One result.
  typedef struct packed {
    logic [15:0] pseudo_checksum;
    logic [31:0] final_destination;
    logic        route_used;
    logic        header_short;
  } iphc_out_t;

  // Parsed header summary handed from the parser to the checksum unit.
  typedef struct packed {
    logic [15:0] partial_checksum;
    logic [15:0] transport_length;
    logic [31:0] source_address;
    logic [31:0] final_destination;
    logic [7:0]  protocol_number;
    logic        route_used;
    logic        header_short;
  } iphc_rec_t;

  // Queue status seen by the parser side and the checksum side.
  typedef struct packed {
    logic full;
    logic empty;
  } iphc_q_stat_t;

endpackage

// ===== src/ip_pseudo_header_checksum.sv =====
// After the transfer of the last header byte, a result passes the queue write, the sum register
// and then the fold register before it is valid at the output.
// Throughput: one header byte per cycle while the queue is not full; the parser updates its state with each byte.
// The queue of QUEUE_DEPTH summaries lets the parser keep taking bytes while results wait.
// Reset: synchronous and active high; parser state, queue and pipeline valids clear at once.
module ip_pseudo_header_checksum #(
  parameter int QUEUE_DEPTH = iphc_pkg::IPHC_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               hdr_valid,
  output logic               hdr_ready,
  input  iphc_pkg::iphc_in_t hdr,
  output logic               res_valid,
  input  logic               res_ready,
  output iphc_pkg::iphc_out_t res
);
  import iphc_pkg::*;

  logic         take;
  logic         rec_push;
  iphc_rec_t    push_rec;
  logic         rec_pop;
  iphc_rec_t    head_rec;
  iphc_q_stat_t q_stat;

  // A byte is taken whenever there is room for a possible summary.
  assign hdr_ready = !q_stat.full;
  assign take      = hdr_valid && hdr_ready;

  iphc_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .hdr      (hdr),
    .rec_push (rec_push),
    .rec      (push_rec)
  );

  iphc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (rec_push),
    .push_rec (push_rec),
    .pop      (rec_pop),
    .head_rec (head_rec),
    .stat     (q_stat)
  );

  iphc_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (!q_stat.empty),
    .rec       (head_rec),
    .rec_pop   (rec_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // A summary is never written into a full queue.
  assert property (@(posedge clk) disable iff (rst) rec_push |-> !q_stat.full)
    else $error("summary written into full queue");

  // The transfer of a last byte leaves a summary waiting in the queue.
  assert property (@(posedge clk) disable iff (rst)
    (take && hdr.byte_last) |=> !q_stat.empty)
    else $error("last byte left no summary in the queue");

  // The checksum unit never reads from an empty queue.
  assert property (@(posedge clk) disable iff (rst) rec_pop |-> !q_stat.empty)
    else $error("read from empty queue");

endmodule

// ===== src/iphc_parser.sv =====
module iphc_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  iphc_pkg::iphc_in_t hdr,
  output logic               rec_push,
  output iphc_pkg::iphc_rec_t rec
);
  import iphc_pkg::*;

  logic [5:0]  byte_position, byte_position_next;
  logic [3:0]  header_words, header_words_next;
  logic [7:0]  protocol_number, protocol_number_next;
  logic [31:0] source_address, source_address_next;
  logic [31:0] dest_address, dest_address_next;
  logic [31:0] route_address, route_address_next;
  iphc_phase_t option_phase, option_phase_next;
  logic [7:0]  option_kind, option_kind_next;
  logic [7:0]  option_length, option_length_next;
  logic [5:0]  option_offset, option_offset_next;
  logic        route_found, route_found_next;
  logic        walk_done, walk_done_next;

  logic [7:0]  b;
  logic [5:0]  p;
  logic [5:0]  end_pos;
  logic        walk_en;
  logic [8:0]  opt_end;
  logic [8:0]  stop;
  logic        is_route;
  logic [6:0]  count;

  assign b = hdr.header_byte;
  assign p = byte_position;

  // Field capture and the option walk for the byte in this transfer.
  always_comb begin
    header_words_next    = (p == IPHC_POS_VERSION) ? b[3:0] : header_words;
    protocol_number_next = (p == IPHC_POS_PROTOCOL) ? b : protocol_number;
    source_address_next  = source_address;
    dest_address_next    = dest_address;
    if (p >= IPHC_POS_SRC_LO && p < IPHC_POS_DST_LO) begin
      source_address_next = {source_address[23:0], b};
    end
    if (p >= IPHC_POS_DST_LO && p < IPHC_POS_OPTIONS) begin
      dest_address_next = {dest_address[23:0], b};
    end

    end_pos = {header_words_next, 2'b00};
    walk_en = (p >= IPHC_POS_OPTIONS) && (p < end_pos) && (p < IPHC_POS_MAX) &&
              !walk_done && !route_found;

    opt_end  = {3'b000, option_offset} + {1'b0, b};
    stop     = {3'b000, option_offset} + {1'b0, option_length} - 9'd1;
    is_route = ((option_kind == IPHC_OPT_SSRR) || (option_kind == IPHC_OPT_LSRR)) &&
               (option_length >= IPHC_ROUTE_MIN_LEN);

    option_phase_next  = option_phase;
    option_kind_next   = option_kind;
    option_length_next = option_length;
    option_offset_next = option_offset;
    route_address_next = route_address;
    route_found_next   = route_found;
    walk_done_next     = walk_done;

    if (walk_en) begin
      case (option_phase)
        PH_TYPE: begin
          if (b == IPHC_OPT_EOL) begin
            walk_done_next = 1'b1;
          end else if (b != IPHC_OPT_NOP) begin
            option_kind_next   = b;
            option_offset_next = p;
            option_phase_next  = PH_LEN;
          end
        end
        PH_LEN: begin
          if (b < IPHC_OPT_MIN_LEN || opt_end > {3'b000, end_pos}) begin
            walk_done_next = 1'b1;
          end else begin
            option_length_next = b;
            option_phase_next  = (b == IPHC_OPT_MIN_LEN) ? PH_TYPE : PH_BODY;
          end
        end
        PH_BODY: begin
          // The last four bytes of a source route hold the final hop.
          if (is_route && ({3'b000, p} + IPHC_ROUTE_TAIL_BYTES > stop)) begin
            route_address_next = {route_address[23:0], b};
          end
          if ({3'b000, p} >= stop) begin
            option_phase_next = PH_TYPE;
            if (is_route) begin
              route_found_next = 1'b1;
            end
          end
        end
        default: begin
          option_phase_next = PH_TYPE;
        end
      endcase
    end

    byte_position_next = (p == IPHC_POS_MAX) ? p : p + 6'd1;
  end

  // Summary of the finished header, taken from the updated state.
  assign count    = {1'b0, p} + 7'd1;
  assign rec_push = take && hdr.byte_last;

  always_comb begin
    rec.partial_checksum  = hdr.partial_checksum;
    rec.transport_length  = hdr.transport_length;
    rec.source_address    = source_address_next;
    rec.final_destination = route_found_next ? route_address_next : dest_address_next;
    rec.protocol_number   = protocol_number_next;
    rec.route_used        = route_found_next;
    rec.header_short      = (count < IPHC_MIN_HDR_BYTES) || (count < {1'b0, end_pos});
  end

  // Parser state; a last byte returns everything to its reset value.
  always_ff @(posedge clk) begin
    if (rst || (take && hdr.byte_last)) begin
      byte_position   <= '0;
      header_words    <= '0;
      protocol_number <= '0;
      source_address  <= '0;
      dest_address    <= '0;
      route_address   <= '0;
      option_phase    <= PH_TYPE;
      option_kind     <= '0;
      option_length   <= '0;
      option_offset   <= '0;
      route_found     <= 1'b0;
      walk_done       <= 1'b0;
    end else if (take) begin
      byte_position   <= byte_position_next;
      header_words    <= header_words_next;
      protocol_number <= protocol_number_next;
      source_address  <= source_address_next;
      dest_address    <= dest_address_next;
      route_address   <= route_address_next;
      option_phase    <= option_phase_next;
      option_kind     <= option_kind_next;
      option_length   <= option_length_next;
      option_offset   <= option_offset_next;
      route_found     <= route_found_next;
      walk_done       <= walk_done_next;
    end
  end

endmodule

// ===== src/iphc_queue.sv =====
module iphc_queue #(
  parameter int DEPTH = iphc_pkg::IPHC_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  iphc_pkg::iphc_rec_t    push_rec,
  input  logic                   pop,
  output iphc_pkg::iphc_rec_t    head_rec,
  output iphc_pkg::iphc_q_stat_t stat
);
  import iphc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  iphc_rec_t     slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign stat.full  = (count == FULL_CNT);
  assign stat.empty = (count == '0);
  assign head_rec   = slots[rd_ptr];

  // Record storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== src/iphc_sum.sv =====
module iphc_sum (
  input  logic                clk,
  input  logic                rst,
  input  logic                rec_valid,
  input  iphc_pkg::iphc_rec_t rec,
  output logic                rec_pop,
  output logic                res_valid,
  input  logic                res_ready,
  output iphc_pkg::iphc_out_t res
);
  import iphc_pkg::*;

  logic        s1_valid;
  logic [18:0] s1_sum;
  logic [31:0] s1_dst;
  logic        s1_route;
  logic        s1_short;
  logic        s1_ready;
  logic        s2_ready;
  logic [18:0] sum_raw;
  logic [16:0] fold1;
  logic [15:0] fold2;

  assign s2_ready = !res_valid || res_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign rec_pop  = rec_valid && s1_ready;

  // Wide add of all pseudo header words.
  assign sum_raw = {3'b000, ~rec.partial_checksum} +
                   {3'b000, rec.source_address[31:16]} +
                   {3'b000, rec.source_address[15:0]} +
                   {3'b000, rec.final_destination[31:16]} +
                   {3'b000, rec.final_destination[15:0]} +
                   {3'b000, rec.transport_length} +
                   {11'd0, rec.protocol_number};

  // End-around carry fold of the registered sum.
  assign fold1 = {1'b0, s1_sum[15:0]} + {14'd0, s1_sum[18:16]};
  assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

  // Stage one: sum register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      s1_sum   <= sum_raw;
      s1_dst   <= rec.final_destination;
      s1_route <= rec.route_used;
      s1_short <= rec.header_short;
    end
  end

  // Stage two: result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s2_ready) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      res.pseudo_checksum   <= ~fold2;
      res.final_destination <= s1_dst;
      res.route_used        <= s1_route;
      res.header_short      <= s1_short;
    end
  end

endmodule
